@@ sv/nwt_pkg.sv @@
// Shared constants, codes and saturation helper for the Newton interpolator.
`default_nettype none
package nwt_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // method register codes
    localparam logic [1:0] M_FWD = 2'd0;
    localparam logic [1:0] M_BWD = 2'd1;
    localparam logic [1:0] M_DIV = 2'd2;
    localparam logic [1:0] M_INV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_INV  = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;
    localparam logic [1:0] ST_DIV0 = 2'd3;

    typedef struct packed {
        logic signed [31:0] v;
        logic               ovf;
    } sat_t;

    // clip a 34-bit signed value to the signed 32-bit range
    function automatic sat_t sat34(input logic signed [33:0] a);
        sat_t r;
        r.ovf = 1'b0;
        r.v   = a[31:0];
        if (a > 34'sh0_7FFF_FFFF)
        begin
            r.v   = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end
        else if (a < -34'sh0_8000_0000)
        begin
            r.v   = 32'sh8000_0000;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/nwt_div.sv @@
// Radix-2 restoring divider, round to nearest (ties away), saturated result.
`default_nettype none
module nwt_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [DEN_W-1:0] den,
    output logic                         done,
    output logic signed [31:0]           quo,
    output logic                         ovf
);
    import nwt_pkg::*;

    localparam int DVW  = NUM_W + 1;
    localparam int CNTW = $clog2(DVW + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} state_t;

    state_t               state_reg;
    logic [DVW-1:0]       dvd_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     dsr_reg;
    logic                 neg_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 done_reg;
    logic signed [31:0]   quo_reg;
    logic                 ovf_reg;

    logic [NUM_W-1:0]     un;
    logic [DEN_W-1:0]     ud;
    logic [DEN_W:0]       trial;
    logic                 ge;
    logic [DEN_W-1:0]     rem_new;

    assign un      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign ud      = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign trial   = {rem_reg, dvd_reg[DVW-1]};
    assign ge      = trial >= {1'b0, dsr_reg};
    assign rem_new = ge ? DEN_W'(trial - {1'b0, dsr_reg}) : trial[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == D_FIN);
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg   <= DVW'(un) + DVW'(ud >> 1);
                        rem_reg   <= '0;
                        dsr_reg   <= ud;
                        neg_reg   <= num[NUM_W-1] ^ den[DEN_W-1];
                        cnt_reg   <= CNTW'(DVW);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    dvd_reg <= {dvd_reg[DVW-2:0], ge};
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1))
                        state_reg <= D_FIN;
                end
                D_FIN:
                begin
                    if (neg_reg)
                    begin
                        if (dvd_reg > DVW'(33'h0_8000_0000))
                        begin
                            quo_reg <= 32'sh8000_0000;
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            quo_reg <= 32'(~dvd_reg[31:0] + 32'd1);
                            ovf_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (dvd_reg > DVW'(33'h0_7FFF_FFFF))
                        begin
                            quo_reg <= 32'sh7FFF_FFFF;
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            quo_reg <= dvd_reg[31:0];
                            ovf_reg <= 1'b0;
                        end
                    end
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

@@ sv/nwt_mul.sv @@
// Two-stage fixed-point multiplier: product, then round half up and saturate.
`default_nettype none
module nwt_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic                    done,
    output logic signed [31:0]      prod,
    output logic                    ovf
);
    import nwt_pkg::*;

    logic signed [63:0] prod_reg;
    logic               v1_reg;
    logic               done_reg;
    logic signed [31:0] q_reg;
    logic               ovf_reg;
    logic signed [63:0] rnd;
    logic signed [63:0] sh;

    assign rnd = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));
    assign sh  = rnd >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            done_reg <= v1_reg;
            if (start)
                prod_reg <= a * b;
            if (v1_reg)
            begin
                if (sh > 64'sh7FFF_FFFF)
                begin
                    q_reg   <= 32'sh7FFF_FFFF;
                    ovf_reg <= 1'b1;
                end
                else if (sh < -64'sh8000_0000)
                begin
                    q_reg   <= 32'sh8000_0000;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    q_reg   <= sh[31:0];
                    ovf_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = q_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

@@ sv/newton_interpolation.sv @@
// Newton interpolator: a load word is stored without raising busy; an evaluate
// word keeps busy high through n divides for forward and backward differences,
// and n(n-1)/2 divides for divided differences, all on the one shared divider.
// The result appears with a one-cycle done strobe; the receiver cannot stall.
// Reset clears the point count, the method register and all control state.
`default_nettype none
module newton_interpolation #(
    parameter int MAX_POINTS = nwt_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = nwt_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_wr_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               mode,
    input  wire logic               first_point,
    input  wire logic signed [31:0] x_value,
    input  wire logic signed [31:0] y_value,
    output logic                    done,
    output logic signed [31:0]      value,
    output logic [1:0]              status,
    output logic                    saturated
);
    import nwt_pkg::*;

    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int DEN_W = 33;

    // Sequencer states: copy the y values into scratch, then either the
    // equal-spaced flow (h, p, difference passes) or the divided flow.
    typedef enum logic [4:0] {
        S_IDLE, S_COPY,
        S_ES_H, S_ES_H2, S_ES_BASE, S_ES_P, S_ES_PW,
        S_DF_INIT, S_DF_LD, S_DF_RD, S_DF_WR,
        S_FAC, S_FAC_W, S_TERM_W, S_AM, S_AW,
        S_DD_A0, S_DD_A1, S_DD_J, S_DD_LD, S_DD_RD, S_DD_DV, S_DD_DW,
        S_DD_T, S_DD_T2
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         method_reg;
    logic signed [31:0] tgt_reg, tgt_next;
    logic signed [32:0] h_reg, h_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] term_reg, term_next;
    logic signed [31:0] ans_reg, ans_next;
    logic signed [31:0] wcar_reg, wcar_next;
    logic               flag_reg, flag_next;
    logic [CW-1:0]      outer_reg, outer_next;
    logic [CW-1:0]      inner_reg, inner_next;
    logic               done_reg, done_next;
    logic signed [31:0] value_reg, value_next;
    logic [1:0]         status_reg, status_next;
    logic               sat_reg, sat_next;

    // point stores and scratch difference table
    logic signed [31:0] xmem [MAX_POINTS];
    logic signed [31:0] ymem [MAX_POINTS];
    logic signed [31:0] wmem [MAX_POINTS];
    logic [AW-1:0]      xa_addr, xb_addr, y_addr, w_raddr, w_waddr;
    logic signed [31:0] xa_rd, xb_rd, y_rd, w_rd, w_wdata;
    logic               w_we;

    // load path
    logic [CW-1:0]      ld_idx;
    logic               ld_we;

    // shared units
    logic                    div_start, div_done, div_ovf;
    logic signed [NUM_W-1:0] div_num;
    logic signed [DEN_W-1:0] div_den;
    logic signed [31:0]      div_q;
    logic                    mul_start, mul_done, mul_ovf;
    logic signed [31:0]      mul_a, mul_b, mul_q;

    // datapath helpers
    logic               back;
    logic [CW-1:0]      last_c, inc_c, dec_c, sum_c, om1_c, lastj_c;
    logic [AW-1:0]      at_idx;
    logic signed [32:0] xd33, tx33, wd33, ans33;
    logic signed [33:0] off34, fac34;
    sat_t               tx_s, wd_s, fac_s, ans_s;
    logic               fin;
    logic [1:0]         fin_st;

    assign back    = (method_reg == M_BWD);
    assign last_c  = count_reg - 1'b1;
    assign inc_c   = inner_reg + 1'b1;
    assign dec_c   = inner_reg - 1'b1;
    assign sum_c   = inner_reg + outer_reg;
    assign om1_c   = outer_reg - 1'b1;
    assign lastj_c = last_c - outer_reg;
    assign at_idx  = back ? last_c[AW-1:0] : '0;

    assign xd33  = {xa_rd[31], xa_rd} - {xb_rd[31], xb_rd};
    assign tx33  = {tgt_reg[31], tgt_reg} - {xa_rd[31], xa_rd};
    assign wd33  = back ? ({wcar_reg[31], wcar_reg} - {w_rd[31], w_rd})
                        : ({w_rd[31], w_rd} - {wcar_reg[31], wcar_reg});
    assign ans33 = {ans_reg[31], ans_reg} + {mul_q[31], mul_q};
    assign off34 = $signed(34'(om1_c) << FRAC_BITS);
    assign fac34 = back ? ({{2{p_reg[31]}}, p_reg} + off34)
                        : ({{2{p_reg[31]}}, p_reg} - off34);
    assign tx_s  = sat34({tx33[32], tx33});
    assign wd_s  = sat34({wd33[32], wd33});
    assign fac_s = sat34(fac34);
    assign ans_s = sat34({ans33[32], ans33});

    // Load: first_point restarts the set; drop loads once the store is full.
    assign ld_idx = first_point ? '0 : count_reg;
    assign ld_we  = (state_reg == S_IDLE) && start && !mode
                    && (ld_idx < CW'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            xmem[ld_idx[AW-1:0]] <= x_value;
            ymem[ld_idx[AW-1:0]] <= y_value;
        end
        if (w_we)
            wmem[w_waddr] <= w_wdata;
        xa_rd <= xmem[xa_addr];
        xb_rd <= xmem[xb_addr];
        y_rd  <= ymem[y_addr];
        w_rd  <= wmem[w_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        tgt_next    = tgt_reg;
        h_next      = h_reg;
        p_next      = p_reg;
        term_next   = term_reg;
        ans_next    = ans_reg;
        wcar_next   = wcar_reg;
        flag_next   = flag_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        status_next = status_reg;
        sat_next    = sat_reg;
        xa_addr     = '0;
        xb_addr     = '0;
        y_addr      = '0;
        w_raddr     = '0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_we        = 1'b0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        mul_start   = 1'b0;
        mul_a       = term_reg;
        mul_b       = '0;
        fin         = 1'b0;
        fin_st      = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!mode)
                    begin
                        if (ld_we)
                            count_next = ld_idx + 1'b1;
                    end
                    else
                    begin
                        tgt_next   = x_value;
                        flag_next  = 1'b0;
                        term_next  = 32'sd1 <<< FRAC_BITS;
                        inner_next = '0;
                        if (method_reg == M_INV)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_INV;
                        end
                        else if (count_reg < CW'(2))
                        begin
                            fin    = 1'b1;
                            fin_st = ST_FEW;
                        end
                        else
                            state_next = S_COPY;
                    end
                end
            end
            // copy y values into scratch, one word a cycle, write one behind
            S_COPY:
            begin
                y_addr = inner_reg[AW-1:0];
                if (inner_reg != '0)
                begin
                    w_we    = 1'b1;
                    w_waddr = dec_c[AW-1:0];
                    w_wdata = y_rd;
                end
                if (inner_reg == count_reg)
                    state_next = (method_reg == M_DIV) ? S_DD_A0 : S_ES_H;
                else
                    inner_next = inc_c;
            end
            S_ES_H:
            begin
                xa_addr    = AW'(1);
                xb_addr    = '0;
                state_next = S_ES_H2;
            end
            S_ES_H2:
            begin
                h_next = xd33;
                if (xd33 == '0)
                begin
                    fin    = 1'b1;
                    fin_st = ST_DIV0;
                end
                else
                    state_next = S_ES_BASE;
            end
            S_ES_BASE:
            begin
                xa_addr    = at_idx;
                w_raddr    = at_idx;
                state_next = S_ES_P;
            end
            S_ES_P:
            begin
                ans_next   = w_rd;
                div_start  = 1'b1;
                div_num    = NUM_W'(tx33) <<< FRAC_BITS;
                div_den    = h_reg;
                state_next = S_ES_PW;
            end
            S_ES_PW:
            begin
                if (div_done)
                begin
                    p_next     = div_q;
                    flag_next  = flag_reg | div_ovf;
                    outer_next = CW'(1);
                    state_next = S_DF_INIT;
                end
            end
            // one difference pass; hold the old neighbor in wcar
            S_DF_INIT:
            begin
                w_raddr    = back ? last_c[AW-1:0] : '0;
                inner_next = back ? last_c : '0;
                state_next = S_DF_LD;
            end
            S_DF_LD:
            begin
                wcar_next  = w_rd;
                state_next = S_DF_RD;
            end
            S_DF_RD:
            begin
                w_raddr    = back ? dec_c[AW-1:0] : inc_c[AW-1:0];
                state_next = S_DF_WR;
            end
            S_DF_WR:
            begin
                w_we      = 1'b1;
                w_waddr   = inner_reg[AW-1:0];
                w_wdata   = wd_s.v;
                flag_next = flag_reg | wd_s.ovf;
                wcar_next = w_rd;
                if (back ? (inner_reg == outer_reg) : (inner_reg == lastj_c))
                    state_next = S_FAC;
                else
                begin
                    inner_next = back ? dec_c : inc_c;
                    state_next = S_DF_RD;
                end
            end
            S_FAC:
            begin
                flag_next  = flag_reg | fac_s.ovf;
                div_start  = 1'b1;
                div_num    = NUM_W'(fac_s.v);
                div_den    = $signed({{(DEN_W - CW){1'b0}}, outer_reg});
                state_next = S_FAC_W;
            end
            S_FAC_W:
            begin
                if (div_done)
                begin
                    flag_next  = flag_reg | div_ovf;
                    mul_start  = 1'b1;
                    mul_b      = div_q;
                    state_next = S_TERM_W;
                end
            end
            S_TERM_W:
            begin
                w_raddr = at_idx;
                if (mul_done)
                begin
                    term_next  = mul_q;
                    flag_next  = flag_reg | mul_ovf;
                    state_next = S_AM;
                end
            end
            S_AM:
            begin
                w_raddr    = at_idx;
                mul_start  = 1'b1;
                mul_b      = w_rd;
                state_next = S_AW;
            end
            S_AW:
            begin
                if (mul_done)
                begin
                    ans_next  = ans_s.v;
                    flag_next = flag_reg | mul_ovf | ans_s.ovf;
                    if (outer_reg == last_c)
                        fin = 1'b1;
                    else
                    begin
                        outer_next = outer_reg + 1'b1;
                        state_next = (method_reg == M_DIV) ? S_DD_J : S_DF_INIT;
                    end
                end
            end
            // divided differences
            S_DD_A0:
            begin
                w_raddr    = '0;
                state_next = S_DD_A1;
            end
            S_DD_A1:
            begin
                ans_next   = w_rd;
                outer_next = CW'(1);
                state_next = S_DD_J;
            end
            S_DD_J:
            begin
                w_raddr    = '0;
                inner_next = '0;
                state_next = S_DD_LD;
            end
            S_DD_LD:
            begin
                wcar_next  = w_rd;
                state_next = S_DD_RD;
            end
            S_DD_RD:
            begin
                w_raddr    = inc_c[AW-1:0];
                xa_addr    = sum_c[AW-1:0];
                xb_addr    = inner_reg[AW-1:0];
                state_next = S_DD_DV;
            end
            S_DD_DV:
            begin
                if (xd33 == '0)
                begin
                    fin    = 1'b1;
                    fin_st = ST_DIV0;
                end
                else
                begin
                    flag_next  = flag_reg | wd_s.ovf;
                    div_start  = 1'b1;
                    div_num    = NUM_W'(wd_s.v) <<< FRAC_BITS;
                    div_den    = xd33;
                    wcar_next  = w_rd;
                    state_next = S_DD_DW;
                end
            end
            S_DD_DW:
            begin
                if (div_done)
                begin
                    w_we      = 1'b1;
                    w_waddr   = inner_reg[AW-1:0];
                    w_wdata   = div_q;
                    flag_next = flag_reg | div_ovf;
                    if (inner_reg == lastj_c)
                        state_next = S_DD_T;
                    else
                    begin
                        inner_next = inc_c;
                        state_next = S_DD_RD;
                    end
                end
            end
            S_DD_T:
            begin
                xa_addr    = om1_c[AW-1:0];
                state_next = S_DD_T2;
            end
            S_DD_T2:
            begin
                flag_next  = flag_reg | tx_s.ovf;
                mul_start  = 1'b1;
                mul_b      = tx_s.v;
                state_next = S_TERM_W;
            end
            default: state_next = S_IDLE;
        endcase

        // finish: strobe done for one cycle, zero value and flag on error
        if (fin)
        begin
            done_next   = 1'b1;
            status_next = fin_st;
            value_next  = (fin_st == ST_OK) ? ans_next : '0;
            sat_next    = (fin_st == ST_OK) ? flag_next : 1'b0;
            state_next  = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            method_reg <= M_FWD;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            value_reg  <= '0;
            sat_reg    <= 1'b0;
            flag_reg   <= 1'b0;
            outer_reg  <= '0;
            inner_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            value_reg  <= value_next;
            sat_reg    <= sat_next;
            flag_reg   <= flag_next;
            outer_reg  <= outer_next;
            inner_reg  <= inner_next;
            if (cfg_wr_en)
                method_reg <= cfg_wr_data;
        end
    end

    // datapath words, no reset needed
    always_ff @(posedge clk)
    begin
        tgt_reg  <= tgt_next;
        h_reg    <= h_next;
        p_reg    <= p_next;
        term_reg <= term_next;
        ans_reg  <= ans_next;
        wcar_reg <= wcar_next;
    end

    nwt_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q),
        .ovf   (div_ovf)
    );

    nwt_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_q),
        .ovf   (mul_ovf)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the Newton interpolator: load and evaluate words against a predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nwt_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint Q1 = longint'(1) << FRAC;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam bit MODE_LOAD = 1'b0;
    localparam bit MODE_EVAL = 1'b1;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               saturated;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [1:0]         cfg_wr_data;
    logic               start;
    logic               busy;
    logic               mode;
    logic               first_point;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic               done;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               saturated;

    newton_interpolation i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .first_point (first_point),
        .x_value     (x_value),
        .y_value     (y_value),
        .done        (done),
        .value       (value),
        .status      (status),
        .saturated   (saturated)
    );

    // Shadow copy of the block's state, kept in step with every accepted word.
    longint     x_store [NPTS];
    longint     y_store [NPTS];
    int         n_loaded;
    logic [1:0] method_reg;

    result_t    pending_results [$];
    int         errors;
    bit         idle_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #40ms;
        $display("FAIL newton_interpolation");
        $finish;
    end

    // ---------------------------------------------------------------
    // Fixed-point arithmetic of the interpolator
    // ---------------------------------------------------------------

    // Clip to the signed 32-bit range and flag any clipping.
    function automatic longint clip(input longint v, inout bit hit);
        if (v > S32_HI)
        begin
            hit = 1'b1;
            return S32_HI;
        end
        if (v < S32_LO)
        begin
            hit = 1'b1;
            return S32_LO;
        end
        return v;
    endfunction

    // Divide rounding to nearest, ties away from zero.
    function automatic longint div_round(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Q product: round half up, arithmetic shift floors.
    function automatic longint q_mul(input longint a, input longint b, inout bit hit);
        return clip((a * b + (Q1 >>> 1)) >>> FRAC, hit);
    endfunction

    // Forward or backward differences on equally spaced points.
    function automatic logic [1:0] eval_equal(input longint tgt, input bit back,
                                              output longint res, inout bit hit);
        longint w [NPTS];
        longint h;
        longint p;
        longint term;
        longint factor;
        int     at;
        res = 0;
        h   = x_store[1] - x_store[0];
        if (h == 0)
            return ST_DIV0;
        w    = y_store;
        at   = back ? n_loaded - 1 : 0;
        p    = clip(div_round((tgt - x_store[at]) * Q1, h), hit);
        term = Q1;
        res  = w[at];
        for (int i = 1; i < n_loaded; i++)
        begin
            if (back)
            begin
                for (int j = n_loaded - 1; j >= i; j--)
                    w[j] = clip(w[j] - w[j-1], hit);
                factor = clip(p + longint'(i - 1) * Q1, hit);
            end
            else
            begin
                for (int j = 0; j < n_loaded - i; j++)
                    w[j] = clip(w[j+1] - w[j], hit);
                factor = clip(p - longint'(i - 1) * Q1, hit);
            end
            term = q_mul(term, clip(div_round(factor, i), hit), hit);
            res  = clip(res + q_mul(term, w[at], hit), hit);
        end
        return ST_OK;
    endfunction

    // Divided differences; a repeated abscissa stops the table build.
    function automatic logic [1:0] eval_divided(input longint tgt, output longint res,
                                                inout bit hit);
        longint w [NPTS];
        longint term;
        longint den;
        res  = 0;
        w    = y_store;
        term = Q1;
        res  = w[0];
        for (int j = 1; j < n_loaded; j++)
        begin
            for (int i = 0; i < n_loaded - j; i++)
            begin
                den = x_store[i+j] - x_store[i];
                if (den == 0)
                    return ST_DIV0;
                w[i] = clip(div_round(clip(w[i+1] - w[i], hit) * Q1, den), hit);
            end
            term = q_mul(term, clip(tgt - x_store[j-1], hit), hit);
            res  = clip(res + q_mul(term, w[0], hit), hit);
        end
        return ST_OK;
    endfunction

    // Update the shadow state for one accepted word; queue the result of an evaluate.
    function automatic void predict_word(input bit md, input bit fp,
                                         input logic signed [31:0] xv,
                                         input logic signed [31:0] yv);
        result_t r;
        longint  res;
        bit      hit;
        if (md == MODE_LOAD)
        begin
            if (fp)
                n_loaded = 0;
            // drop loads beyond a full store
            if (n_loaded < NPTS)
            begin
                x_store[n_loaded] = longint'(xv);
                y_store[n_loaded] = longint'(yv);
                n_loaded++;
            end
            return;
        end
        hit = 1'b0;
        res = 0;
        if (method_reg == M_INV)
            r.status = ST_INV;
        else if (n_loaded < 2)
            r.status = ST_FEW;
        else if (method_reg == M_DIV)
            r.status = eval_divided(longint'(xv), res, hit);
        else
            r.status = eval_equal(longint'(xv), method_reg == M_BWD, res, hit);
        if (r.status != ST_OK)
        begin
            res = 0;
            hit = 1'b0;
        end
        r.value     = res[31:0];
        r.saturated = hit;
        pending_results = {pending_results, r};
    endfunction

    // ---------------------------------------------------------------
    // Result checker: done is a one-cycle strobe, no back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result value=%h status=%0d sat=%0b",
                         $realtime, value, status, saturated);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                begin
                    $display("%0t: value expected %h actual %h", $realtime, want.value, value);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, status);
                    errors++;
                end
                if (saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $realtime, want.saturated, saturated);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Word driver and register write
    // ---------------------------------------------------------------

    // Send one word. Returns in the time step of the accepting edge with start
    // still high; the next action in that step must drive start again.
    task automatic send_word(input bit md, input bit fp,
                             input logic signed [31:0] xv,
                             input logic signed [31:0] yv);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= md;
        first_point <= fp;
        x_value     <= xv;
        y_value     <= yv;
        // busy only moves at rising edges, so the falling edge gives a clean look
        do @(negedge clk); while (busy);
        @(posedge clk);
        predict_word(md, fp, xv, yv);
    endtask

    // Hold until the block is idle, then write the method register.
    task automatic set_method(input logic [1:0] m);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        do @(negedge clk); while (busy);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        method_reg = m;
    endtask

    // Load n points at x0, x0+h, ...; wide picks full-range ordinates.
    task automatic load_points(input int n, input logic signed [31:0] x0,
                               input logic signed [31:0] h, input bit wide);
        logic signed [31:0] yv;
        for (int i = 0; i < n; i++)
        begin
            yv = wide ? $urandom : $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            send_word(MODE_LOAD, i == 0, x0 + i * h, yv);
        end
    endtask

    task automatic evaluate_at(input logic signed [31:0] xv);
        send_word(MODE_EVAL, $urandom_range(0, 1), xv, $urandom);
    endtask

    // ---------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------

    // Too few points for the forward and divided methods, and the invalid method code.
    task automatic test_status_codes();
        set_method(M_FWD);
        evaluate_at(32'sh0001_0000);
        load_points(1, 32'sh0000_0000, 32'sh0001_0000, 1'b0);
        set_method(M_DIV);
        evaluate_at(32'sh0000_8000);
        set_method(M_INV);
        load_points(3, 32'sh0000_0000, 32'sh0001_0000, 1'b0);
        evaluate_at(32'sh0000_8000);
    endtask

    // Each method on small equally spaced sets, targets inside and at the first point.
    task automatic test_methods();
        for (int m = M_FWD; m <= M_DIV; m++)
        begin
            set_method(m[1:0]);
            load_points(4, -32'sh0002_0000, 32'sh0001_0000, 1'b0);
            evaluate_at(32'sh0000_8000);
            evaluate_at(-32'sh0002_0000);
        end
    endtask

    // Extreme field values: full-scale ordinates and targets drive saturation.
    task automatic test_extremes();
        set_method(M_FWD);
        send_word(MODE_LOAD, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(MODE_LOAD, 1'b0, 32'sh8001_0000, 32'sh8000_0000);
        send_word(MODE_LOAD, 1'b0, 32'sh8002_0000, 32'sh7FFF_FFFF);
        evaluate_at(32'sh7FFF_FFFF);
        set_method(M_DIV);
        evaluate_at(32'sh8000_0000);
    endtask

    // Zero spacing for forward/backward, a repeated abscissa for divided.
    task automatic test_zero_divisor();
        set_method(M_BWD);
        load_points(3, 32'sh0003_0000, 32'sh0000_0000, 1'b0);
        evaluate_at(32'sh0003_0000);
        set_method(M_DIV);
        send_word(MODE_LOAD, 1'b1, 32'sh0000_0000, 32'sh0001_0000);
        send_word(MODE_LOAD, 1'b0, 32'sh0001_0000, 32'sh0002_0000);
        send_word(MODE_LOAD, 1'b0, 32'sh0000_0000, 32'sh0003_0000);
        evaluate_at(32'sh0000_8000);
    endtask

    // Store full: the seventeenth load is dropped.
    task automatic test_store_full();
        set_method(M_DIV);
        load_points(NPTS + 1, -32'sh0008_0000, 32'sh0001_0000, 1'b0);
        evaluate_at(32'sh0000_4000);
    endtask

    // ---------------------------------------------------------------
    // Random test: mostly clean point sets, some noise
    // ---------------------------------------------------------------
    task automatic test_random(input int rounds);
        int                 n;
        logic signed [31:0] x0;
        logic signed [31:0] h;
        for (int r = 0; r < rounds; r++)
        begin
            if (r >= rounds - 6)
                idle_on = 1'b0;
            set_method(($urandom_range(0, 9) == 0) ? M_INV : 2'($urandom_range(0, 2)));
            if ($urandom_range(0, 4) != 0)
            begin
                // a clean set, mostly small so evaluation stays short
                n  = ($urandom_range(0, 11) == 0) ? NPTS : $urandom_range(2, 6);
                x0 = ($urandom_range(0, 5) == 0) ? $urandom
                                                 : $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                case ($urandom_range(0, 9))
                    0:       h = $urandom;
                    1:       h = 0;
                    default: h = ($urandom_range(1, 8) << 16) + $urandom_range(0, 255);
                endcase
                if ($urandom_range(0, 1))
                    h = -h;
                load_points(n, x0, h, $urandom_range(0, 4) == 0);
                repeat ($urandom_range(1, 2))
                    evaluate_at(($urandom_range(0, 7) == 0) ? $urandom
                                : x0 + $urandom_range(0, 32'h0008_0000) - 32'h0002_0000);
            end
            else
            begin
                // noise: random words, first_point at random
                repeat ($urandom_range(2, 5))
                    send_word($urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int wait_cycles;
        errors      = 0;
        n_loaded    = 0;
        method_reg  = M_FWD;
        idle_on     = 1'b1;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = M_FWD;
        start       = 1'b0;
        mode        = MODE_LOAD;
        first_point = 1'b0;
        x_value     = '0;
        y_value     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_status_codes();
        test_methods();
        test_extremes();
        test_zero_divisor();
        test_store_full();
        test_random(16);

        // drain: wait out the last evaluation, then let the bench idle before the verdict
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS newton_interpolation");
        else
            $display("FAIL newton_interpolation");
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
sv/nwt_pkg.sv
sv/nwt_div.sv
sv/nwt_mul.sv
sv/newton_interpolation.sv
verif/testbench.sv
